// ===== design/bts_pkg.sv =====
// bts_pkg: shared types, constants and codes of the bilinear texture sampler
// used by bts_fifo, bts_front, bts_back and bilinear_texture_sampler
package bts_pkg;

   // field widths
   localparam int CFG_W       = 9;
   localparam int COORD_W     = 32;
   localparam int INDEX_W     = 16;
   localparam int TEXEL_W     = 8;
   localparam int FRAC_W      = 16;
   localparam int WEIGHT_W    = FRAC_W + 1;
   localparam int POS_W       = 25;
   localparam int ROWADDR_W   = 2 * CFG_W;
   localparam int ROW_W       = 24;
   localparam int PROD_W      = 40;
   localparam int SAMPLE_W    = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int NUM_TAPS    = 4;
   localparam int TAP_W       = 2;
   localparam int STORE_DEPTH = 65536;

   // fixed point constants
   localparam logic [WEIGHT_W-1:0] ONE_Q16  = WEIGHT_W'(65536);
   localparam logic [FRAC_W-1:0]   HALF_Q16 = FRAC_W'(32768);

   // defaults handed to the top level
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_CMD_DEPTH  = 4;
   localparam int DEF_RSP_DEPTH  = 4;
   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_HEIGHT = 1'b1;

   // opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // neighbour taps in fetch order
   localparam logic [TAP_W-1:0] TAP_00 = 2'd0;
   localparam logic [TAP_W-1:0] TAP_10 = 2'd1;
   localparam logic [TAP_W-1:0] TAP_01 = 2'd2;
   localparam logic [TAP_W-1:0] TAP_11 = 2'd3;

   // command passed from front to back
   typedef struct packed {
      logic                              is_sample;
      logic [TEXEL_W-1:0]                value;
      logic [NUM_TAPS-1:0][INDEX_W-1:0]  addr;
      logic [FRAC_W-1:0]                 tx;
      logic [FRAC_W-1:0]                 ty;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } bk_state_type;

endpackage

// ===== design/bts_fifo.sv =====
// bts_fifo: small first-in first-out queue in flip-flops
// depends on bts_pkg for the status struct
module bts_fifo
   import bts_pkg::*;
#(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = DEF_CMD_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] pop_data,
   output fifo_status_type       status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = store_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== design/bts_front.sv =====
// bts_front: accepts request words and turns samples into four texel addresses and weights
// depends on bts_pkg; three register stages feeding the command queue
module bts_front
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_opcode,
   input  logic [INDEX_W-1:0]        req_texel_index,
   input  logic [TEXEL_W-1:0]        req_texel_value,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   input  logic [CFG_W-1:0]          width_reg,
   input  logic [CFG_W-1:0]          height_reg,
   output logic                      cmd_push,
   output cmd_type                   cmd_data,
   input  logic                      cmd_full
);

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] dim,
                                                  input int maxv);
      logic [CFG_W-1:0] res;
      if (dim == '0) begin
         res = CFG_W'(1);
      end else if (int'(dim) > maxv) begin
         res = CFG_W'(maxv);
      end else begin
         res = dim;
      end
      return res;
   endfunction

   logic [CFG_W-1:0]    w, h;
   logic                enable, accept;
   logic [WEIGHT_W-1:0] vflip;

   // stage 1: scaled positions
   logic                s1_valid_ff;
   logic                s1_sample_ff;
   logic [INDEX_W-1:0]  s1_index_ff;
   logic [TEXEL_W-1:0]  s1_value_ff;
   logic [POS_W-1:0]    s1_xpos_ff, s1_xpos_in;
   logic [POS_W-1:0]    s1_ypos_ff, s1_ypos_in;

   // stage 2: wrapped cells and weights
   logic                s2_valid_ff;
   logic                s2_sample_ff;
   logic [INDEX_W-1:0]  s2_index_ff;
   logic [TEXEL_W-1:0]  s2_value_ff;
   logic [CFG_W-1:0]    s2_x0_ff, s2_x1_ff, s2_y0_ff, s2_y1_ff;
   logic [CFG_W-1:0]    s2_x0_in, s2_x1_in, s2_y0_in, s2_y1_in;
   logic [FRAC_W-1:0]   s2_tx_ff, s2_ty_ff;
   logic [CFG_W-1:0]    xcell, ycell;

   // stage 3: command word
   logic                s3_valid_ff;
   cmd_type             s3_cmd_ff, s3_cmd_in;
   logic [ROWADDR_W-1:0] row0, row1;

   assign w = clamp_dim(width_reg, MAX_WIDTH);
   assign h = clamp_dim(height_reg, MAX_HEIGHT);

   // whole pipe holds while the last stage waits on the queue
   assign enable   = !(s3_valid_ff && cmd_full);
   assign req_full = !enable;
   assign accept   = req_push && enable;
   assign cmd_push = s3_valid_ff && !cmd_full;
   assign cmd_data = s3_cmd_ff;

   always_comb begin
      vflip      = ONE_Q16 - WEIGHT_W'(req_v_coord[FRAC_W-1:0]);
      s1_xpos_in = POS_W'(req_u_coord[FRAC_W-1:0]) * POS_W'(w) + POS_W'(HALF_Q16);
      s1_ypos_in = POS_W'(vflip) * POS_W'(h) + POS_W'(HALF_Q16);
   end

   // cell index plus one sits in the integer bits and is at most the size
   always_comb begin
      xcell    = s1_xpos_ff[POS_W-1:FRAC_W];
      ycell    = s1_ypos_ff[POS_W-1:FRAC_W];
      s2_x1_in = (xcell == w) ? '0 : xcell;
      s2_y1_in = (ycell == h) ? '0 : ycell;
      s2_x0_in = (xcell == '0) ? (w - CFG_W'(1)) : (xcell - CFG_W'(1));
      s2_y0_in = (ycell == '0) ? (h - CFG_W'(1)) : (ycell - CFG_W'(1));
   end

   always_comb begin
      row0                  = ROWADDR_W'(s2_y0_ff) * ROWADDR_W'(w);
      row1                  = ROWADDR_W'(s2_y1_ff) * ROWADDR_W'(w);
      s3_cmd_in.is_sample   = s2_sample_ff;
      s3_cmd_in.value       = s2_value_ff;
      s3_cmd_in.tx          = s2_tx_ff;
      s3_cmd_in.ty          = s2_ty_ff;
      if (s2_sample_ff) begin
         s3_cmd_in.addr[TAP_00] = INDEX_W'(row0 + ROWADDR_W'(s2_x0_ff));
         s3_cmd_in.addr[TAP_10] = INDEX_W'(row0 + ROWADDR_W'(s2_x1_ff));
         s3_cmd_in.addr[TAP_01] = INDEX_W'(row1 + ROWADDR_W'(s2_x0_ff));
         s3_cmd_in.addr[TAP_11] = INDEX_W'(row1 + ROWADDR_W'(s2_x1_ff));
      end else begin
         s3_cmd_in.addr         = '0;
         s3_cmd_in.addr[TAP_00] = s2_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_sample_ff <= (req_opcode == OP_SAMPLE);
         s1_index_ff  <= req_texel_index;
         s1_value_ff  <= req_texel_value;
         s1_xpos_ff   <= s1_xpos_in;
         s1_ypos_ff   <= s1_ypos_in;
         s2_sample_ff <= s1_sample_ff;
         s2_index_ff  <= s1_index_ff;
         s2_value_ff  <= s1_value_ff;
         s2_x0_ff     <= s2_x0_in;
         s2_x1_ff     <= s2_x1_in;
         s2_y0_ff     <= s2_y0_in;
         s2_y1_ff     <= s2_y1_in;
         s2_tx_ff     <= s1_xpos_ff[FRAC_W-1:0];
         s2_ty_ff     <= s1_ypos_ff[FRAC_W-1:0];
         s3_cmd_ff    <= s3_cmd_in;
      end
   end

endmodule

// ===== design/bts_back.sv =====
// bts_back: texel memory, four-read fetch sequencer and bilinear blend pipeline
// depends on bts_pkg; takes commands from the queue, pushes words to the result queue
module bts_back
   import bts_pkg::*;
#(
   parameter int RSP_DEPTH = DEF_RSP_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd_head,
   input  fifo_status_type      cmd_status,
   output logic                 cmd_pop,
   input  logic                 rsp_release,
   output logic                 rsp_push,
   output logic [SAMPLE_W-1:0]  rsp_data
);

   localparam int USED_W = $clog2(RSP_DEPTH + 1);

   logic [TEXEL_W-1:0] mem [STORE_DEPTH];

   bk_state_type       state_ff, state_in;
   logic [TAP_W-1:0]   cnt_ff, cnt_in;
   cmd_type            cmd_ff;
   logic [USED_W-1:0]  used_ff, used_in;
   logic               credit_ok;

   logic               mem_we, mem_re, load_cmd;
   logic [INDEX_W-1:0] mem_addr;
   logic [TAP_W-1:0]   rd_tag;

   logic               rd_valid_ff;
   logic [TAP_W-1:0]   rd_tag_ff;
   logic [TEXEL_W-1:0] rd_data_ff;
   logic [NUM_TAPS-2:0][TEXEL_W-1:0] tex_ff;

   logic [WEIGHT_W-1:0] itx, ity;
   logic                a_valid_ff;
   logic [ROW_W-1:0]    row0_ff, row1_ff;
   logic [WEIGHT_W-1:0] ity_ff;
   logic [FRAC_W-1:0]   ty_ff;
   logic                b_valid_ff;
   logic [PROD_W-1:0]   p0_ff, p1_ff, sum;

   assign credit_ok = (used_ff < USED_W'(RSP_DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_status.empty && cmd_head.is_sample && credit_ok) begin
               state_in = BK_READ;
               cnt_in   = TAP_10;
            end
         end
         BK_READ: begin
            cnt_in = cnt_ff + TAP_W'(1);
            if (cnt_ff == TAP_11) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      load_cmd = 1'b0;
      mem_addr = cmd_head.addr[TAP_00];
      rd_tag   = TAP_00;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_status.empty) begin
               if (!cmd_head.is_sample) begin
                  cmd_pop = 1'b1;
                  mem_we  = 1'b1;
               end else if (credit_ok) begin
                  cmd_pop  = 1'b1;
                  mem_re   = 1'b1;
                  load_cmd = 1'b1;
               end
            end
         end
         BK_READ: begin
            mem_re   = 1'b1;
            mem_addr = cmd_ff.addr[cnt_ff];
            rd_tag   = cnt_ff;
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   always_comb begin
      used_in = used_ff + USED_W'(load_cmd) - USED_W'(rsp_release);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         cnt_ff      <= TAP_00;
         used_ff     <= '0;
         rd_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         used_ff     <= used_in;
         rd_valid_ff <= mem_re;
         a_valid_ff  <= rd_valid_ff && (rd_tag_ff == TAP_11);
         b_valid_ff  <= a_valid_ff;
      end
   end

   // texel memory, one port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= cmd_head.value;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff <= rd_tag;
      if (load_cmd) begin
         cmd_ff <= cmd_head;
      end
      if (rd_valid_ff && (rd_tag_ff != TAP_11)) begin
         tex_ff[rd_tag_ff] <= rd_data_ff;
      end
   end

   // blend: horizontal lerp of both rows, then vertical weights, then sum
   assign itx = ONE_Q16 - WEIGHT_W'(cmd_ff.tx);
   assign ity = ONE_Q16 - WEIGHT_W'(cmd_ff.ty);

   always_ff @(posedge clock) begin
      row0_ff <= ROW_W'(ROW_W'(tex_ff[TAP_00]) * ROW_W'(itx)
                      + ROW_W'(tex_ff[TAP_10]) * ROW_W'(cmd_ff.tx));
      row1_ff <= ROW_W'(ROW_W'(tex_ff[TAP_01]) * ROW_W'(itx)
                      + ROW_W'(rd_data_ff) * ROW_W'(cmd_ff.tx));
      ity_ff  <= ity;
      ty_ff   <= cmd_ff.ty;
      p0_ff   <= PROD_W'(row0_ff) * PROD_W'(ity_ff);
      p1_ff   <= PROD_W'(row1_ff) * PROD_W'(ty_ff);
   end

   assign sum      = p0_ff + p1_ff;
   assign rsp_push = b_valid_ff;
   assign rsp_data = sum[PROD_W-1:FRAC_W];

endmodule

// ===== design/bilinear_texture_sampler.sv =====
// bilinear_texture_sampler: top level, configuration registers and queues
// depends on bts_pkg, bts_fifo, bts_front and bts_back
//
// Greyscale bilinear sampler with repeat wrapping over a 65536 x 8-bit texel
// memory. A request word with opcode write stores texel_value at texel_index
// (row * width + column) and gives no response; a request word with opcode
// sample gives one response word, the blended grey level in unsigned Q8.16.
// Only the low 16 bits of u and v matter, v is flipped so that zero is the
// texture bottom. Throughput is set by the single texel memory port: a sample
// uses it for one read per neighbour and a write for one access, and no new
// command is taken until a sample has done its four reads. A request passes 3
// front stages, the command queue, 4 reads and the blend stages (row lerp, then
// weighted products) before its response is pushed. Texel memory has no reset
// and needs no clearing pass; a texel must be written before a sample reads it.
// The user writes width and height registers only while the block is idle; the
// block does not enforce it. Zero reads as one and values above the maximums saturate.
module bilinear_texture_sampler
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int CMD_DEPTH  = DEF_CMD_DEPTH,
   parameter int RSP_DEPTH  = DEF_RSP_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // request side
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_opcode,
   input  logic [INDEX_W-1:0]        req_texel_index,
   input  logic [TEXEL_W-1:0]        req_texel_value,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   // response side
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [SAMPLE_W-1:0]       rsp_sample_value,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]          csr_data
);

   localparam int CMD_W = $bits(cmd_type);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   logic             cmd_push, cmd_pop;
   cmd_type          cmd_in_word, cmd_head;
   logic [CMD_W-1:0] cmd_head_bits;
   fifo_status_type  cmd_status;

   logic                rsp_push, rsp_release;
   logic [SAMPLE_W-1:0] rsp_data;
   fifo_status_type     rsp_status;

   // config registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TEXTURE_WIDTH:  width_in  = csr_data;
            CSR_TEXTURE_HEIGHT: height_in = csr_data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // front: classify and compute neighbour addresses
   bts_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_texel_index (req_texel_index),
      .req_texel_value (req_texel_value),
      .req_u_coord     (req_u_coord),
      .req_v_coord     (req_v_coord),
      .width_reg       (width_ff),
      .height_reg      (height_ff),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in_word),
      .cmd_full        (cmd_status.full)
   );

   // command queue decouples front from the memory sequencer
   bts_fifo #(
      .DATA_WIDTH (CMD_W),
      .DEPTH      (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_word),
      .pop       (cmd_pop),
      .pop_data  (cmd_head_bits),
      .status    (cmd_status)
   );

   assign cmd_head = cmd_type'(cmd_head_bits);

   // back: memory access and blend
   bts_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_head    (cmd_head),
      .cmd_status  (cmd_status),
      .cmd_pop     (cmd_pop),
      .rsp_release (rsp_release),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_data)
   );

   // response queue; back reserves a slot before starting a sample
   assign rsp_release = rsp_pop && !rsp_status.empty;

   bts_fifo #(
      .DATA_WIDTH (SAMPLE_W),
      .DEPTH      (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .pop       (rsp_release),
      .pop_data  (rsp_sample_value),
      .status    (rsp_status)
   );

   assign rsp_empty = rsp_status.empty;

   // checks
   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_status.full)
      else $error("command queue pushed while full");

   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_status.empty)
      else $error("command queue popped while empty");

   a_rsp_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_status.full)
      else $error("response word arrived with no free slot");

   a_full_needs_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_full |-> cmd_status.full)
      else $error("request side stalled with room in the command queue");

endmodule
